// File: hdl/btl_pkg.sv
package btl_pkg;

    localparam int GLYPH_COUNT     = 95;
    localparam int GLYPH_ADDR_BITS = $clog2(GLYPH_COUNT);
    localparam int COORD_BITS      = 16;
    localparam int SUM_BITS        = COORD_BITS + 2;
    localparam int EXTENT_BITS     = 15;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [7:0] CODE_FIRST   = 8'd32;
    localparam logic [7:0] CODE_LAST    = 8'd126;
    localparam logic [7:0] CODE_QMARK   = 8'd63;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_SKIP   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_HEIGHT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [EXTENT_BITS-1:0]       extent_t;
    typedef logic [GLYPH_ADDR_BITS-1:0]   glyph_addr_t;

    typedef struct packed {
        logic [11:0]       sx;
        logic [11:0]       sy;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] xo;
        logic signed [7:0] yo;
        logic [7:0]        adv;
    } glyph_t;

    localparam int GLYPH_BITS = $bits(glyph_t);

    // per-character control handed from the front end to the layout stage
    typedef struct packed {
        logic   is_newline;
        logic   is_space;
        logic   last;
        coord_t origin_x;
        coord_t origin_y;
    } issue_t;

    localparam coord_t  COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t  COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam sum_t    SUM_CMAX  = {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam sum_t    SUM_CMIN  = {{(SUM_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam extent_t EXT_MAX   = {EXTENT_BITS{1'b1}};
    localparam sum_t    SUM_EMAX  = {{(SUM_BITS-EXTENT_BITS){1'b0}}, {EXTENT_BITS{1'b1}}};

    function automatic sum_t u8_to_sum(input logic [7:0] v);
        return $signed({{(SUM_BITS-8){1'b0}}, v});
    endfunction

    function automatic sum_t coord_to_sum(input coord_t v);
        return sum_t'(v);
    endfunction

    function automatic coord_t sat_coord(input sum_t v);
        coord_t r;
        if (v > SUM_CMAX)
        begin
            r = COORD_MAX;
        end
        else if (v < SUM_CMIN)
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // running maximum of a non-negative extent, clamped at the top
    function automatic extent_t max_extent(input extent_t m, input sum_t c);
        sum_t    ms;
        extent_t r;
        ms = $signed({{(SUM_BITS-EXTENT_BITS){1'b0}}, m});
        if (c > ms)
        begin
            if (c > SUM_EMAX)
            begin
                r = EXT_MAX;
            end
            else
            begin
                r = c[EXTENT_BITS-1:0];
            end
        end
        else
        begin
            r = m;
        end
        return r;
    endfunction

endpackage

// File: hdl/btl_if.sv
interface btl_item_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [7:0]           char_code;
    logic                 last;
    logic [11:0]          src_x;
    logic [11:0]          src_y;
    logic [7:0]           src_w;
    logic [7:0]           src_h;
    logic signed [7:0]    x_offset;
    logic signed [7:0]    y_offset;
    logic [7:0]           advance;
    logic signed [15:0]   origin_x;
    logic signed [15:0]   origin_y;

    modport source (
        output valid, op, char_code, last, src_x, src_y, src_w, src_h,
               x_offset, y_offset, advance, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, op, char_code, last, src_x, src_y, src_w, src_h,
               x_offset, y_offset, advance, origin_x, origin_y,
        output ready
    );
endinterface

interface btl_result_if;
    logic                 valid;
    logic                 ready;
    logic                 draw_valid;
    logic [11:0]          blit_src_x;
    logic [11:0]          blit_src_y;
    logic [7:0]           blit_w;
    logic [7:0]           blit_h;
    logic signed [15:0]   dest_x;
    logic signed [15:0]   dest_y;
    logic signed [15:0]   end_x;
    logic signed [15:0]   end_y;
    logic [14:0]          extent_w;
    logic [14:0]          extent_h;
    logic                 last_out;

    modport source (
        output valid, draw_valid, blit_src_x, blit_src_y, blit_w, blit_h,
               dest_x, dest_y, end_x, end_y, extent_w, extent_h, last_out,
        input  ready
    );
    modport sink (
        input  valid, draw_valid, blit_src_x, blit_src_y, blit_w, blit_h,
               dest_x, dest_y, end_x, end_y, extent_w, extent_h, last_out,
        output ready
    );
endinterface

interface btl_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [btl_pkg::CFG_INDEX_BITS-1:0]    index;
    logic [7:0]                            data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: hdl/btl_ram.sv
module btl_ram #(
    parameter int WIDTH = btl_pkg::GLYPH_BITS,
    parameter int DEPTH = btl_pkg::GLYPH_COUNT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/btl_core.sv
module btl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue_valid,
    input  btl_pkg::issue_t     issue,
    output logic                issue_ready,
    input  btl_pkg::glyph_t     glyph,
    input  logic [7:0]          line_skip,
    input  logic [7:0]          line_height,
    btl_result_if.source        result
);

    // layout stage
    logic               s1_valid_reg, s1_valid_next;
    btl_pkg::issue_t    s1_reg;
    logic               s1_adv;

    // string state
    btl_pkg::coord_t    cx_reg, cy_reg, org_x_reg, org_y_reg;
    btl_pkg::extent_t   mw_reg, mh_reg;
    logic               in_string_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               draw_reg;
    logic [11:0]        bsx_reg, bsy_reg;
    logic [7:0]         bw_reg, bh_reg;
    btl_pkg::coord_t    dx_reg, dy_reg, ex_reg, ey_reg;
    btl_pkg::extent_t   ew_reg, eh_reg;
    logic               last_reg;

    logic               start;
    btl_pkg::coord_t    ox, oy, cx, cy, cx_next, cy_next, dx, dy, ex, ey;
    btl_pkg::extent_t   mw, mh, mw_next, mh_next;
    logic               draw;
    btl_pkg::sum_t      adv_s, lh_s, ls_s, xo_s, yo_s, w_s;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign issue_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue_ready)
        begin
            s1_valid_next = issue_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        start = !in_string_reg;
        ox    = start ? s1_reg.origin_x : org_x_reg;
        oy    = start ? s1_reg.origin_y : org_y_reg;
        cx    = start ? '0 : cx_reg;
        cy    = start ? '0 : cy_reg;
        mw    = start ? '0 : mw_reg;
        mh    = start ? btl_pkg::extent_t'(line_height) : mh_reg;

        adv_s = btl_pkg::u8_to_sum(glyph.adv);
        w_s   = btl_pkg::u8_to_sum(glyph.w);
        lh_s  = btl_pkg::u8_to_sum(line_height);
        ls_s  = btl_pkg::u8_to_sum(line_skip);
        xo_s  = btl_pkg::sum_t'($signed(glyph.xo));
        yo_s  = btl_pkg::sum_t'($signed(glyph.yo));

        draw  = !s1_reg.is_newline && !s1_reg.is_space;

        if (s1_reg.is_newline)
        begin
            cx_next = '0;
            cy_next = btl_pkg::sat_coord(btl_pkg::coord_to_sum(cy) + ls_s);
            mw_next = mw;
        end
        else
        begin
            cx_next = btl_pkg::sat_coord(btl_pkg::coord_to_sum(cx) + adv_s);
            cy_next = cy;
            if (s1_reg.is_space)
            begin
                mw_next = btl_pkg::max_extent(mw, btl_pkg::coord_to_sum(cx) + adv_s);
            end
            else
            begin
                mw_next = btl_pkg::max_extent(mw, btl_pkg::coord_to_sum(cx) + xo_s + w_s);
            end
        end
        mh_next = btl_pkg::max_extent(mh, btl_pkg::coord_to_sum(cy_next) + lh_s);

        dx = btl_pkg::sat_coord(btl_pkg::coord_to_sum(ox) + btl_pkg::coord_to_sum(cx) + xo_s);
        dy = btl_pkg::sat_coord(btl_pkg::coord_to_sum(oy) + btl_pkg::coord_to_sum(cy) + yo_s);
        ex = btl_pkg::sat_coord(btl_pkg::coord_to_sum(ox) + btl_pkg::coord_to_sum(cx_next));
        ey = btl_pkg::sat_coord(btl_pkg::coord_to_sum(oy) + btl_pkg::coord_to_sum(cy_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_string_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            mw_reg        <= '0;
            mh_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                in_string_reg <= !s1_reg.last;
                cx_reg        <= cx_next;
                cy_reg        <= cy_next;
                org_x_reg     <= ox;
                org_y_reg     <= oy;
                mw_reg        <= mw_next;
                mh_reg        <= mh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_ready && issue_valid)
        begin
            s1_reg <= issue;
        end
        if (s1_adv)
        begin
            draw_reg <= draw;
            bsx_reg  <= draw ? glyph.sx : '0;
            bsy_reg  <= draw ? glyph.sy : '0;
            bw_reg   <= draw ? glyph.w : '0;
            bh_reg   <= draw ? glyph.h : '0;
            dx_reg   <= draw ? dx : '0;
            dy_reg   <= draw ? dy : '0;
            ex_reg   <= ex;
            ey_reg   <= ey;
            ew_reg   <= mw_next;
            eh_reg   <= mh_next;
            last_reg <= s1_reg.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.draw_valid = draw_reg;
    assign result.blit_src_x = bsx_reg;
    assign result.blit_src_y = bsy_reg;
    assign result.blit_w     = bw_reg;
    assign result.blit_h     = bh_reg;
    assign result.dest_x     = dx_reg;
    assign result.dest_y     = dy_reg;
    assign result.end_x      = ex_reg;
    assign result.end_y      = ey_reg;
    assign result.extent_w   = ew_reg;
    assign result.extent_h   = eh_reg;
    assign result.last_out   = last_reg;

`ifndef SYNTHESIS
    a_nodraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !draw_reg |-> bw_reg == '0 && bh_reg == '0 &&
            dx_reg == '0 && dy_reg == '0)
        else $error("blit fields not cleared on a beat without a draw");

    a_last_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_reg.last |=> !in_string_reg)
        else $error("string state not closed after last character");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_reg))
        else $error("layout stage lost a stalled character");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg)
        else $error("result beat dropped while stalled");
`endif

endmodule

// File: hdl/bitmap_text_layout_unit.sv
// a character and its glyph read are registered in the layout stage; its result beat is then registered and offered
// throughput: one item per cycle while the result side does not stall; the cursor update in the
// layout stage is combinational and the glyph ram gives one read and one write per cycle
// glyph writes produce no result beat
// reset: cursor, origin, extent and string state clear, line registers go to zero;
// glyph ram is not cleared and must be written before its codes are laid out
module bitmap_text_layout_unit (
    input  logic          clk,
    input  logic          rst_n,
    btl_item_if.sink      item,
    btl_result_if.source  result,
    btl_cfg_if.sink       cfg
);

    logic [7:0]               line_skip_reg, line_skip_next;
    logic [7:0]               line_height_reg, line_height_next;

    logic                     accept;
    logic                     printable;
    logic [7:0]               rd_code;
    logic                     we, re;
    btl_pkg::glyph_addr_t     waddr, raddr;
    btl_pkg::glyph_t          wdata, rdata;
    btl_pkg::issue_t          issue;
    logic                     issue_ready;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        line_skip_next   = line_skip_reg;
        line_height_next = line_height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                btl_pkg::REG_LINE_SKIP:   line_skip_next   = cfg.data;
                btl_pkg::REG_LINE_HEIGHT: line_height_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_skip_reg   <= '0;
            line_height_reg <= '0;
        end
        else
        begin
            line_skip_reg   <= line_skip_next;
            line_height_reg <= line_height_next;
        end
    end

    assign item.ready = issue_ready;
    assign accept     = item.valid && issue_ready;

    always_comb
    begin
        printable = item.char_code >= btl_pkg::CODE_FIRST &&
                    item.char_code <= btl_pkg::CODE_LAST;
        // unprintable bytes fall back to the question mark glyph
        rd_code   = printable ? item.char_code : btl_pkg::CODE_QMARK;

        we    = accept && item.op == btl_pkg::OP_WRITE && printable;
        re    = accept && item.op == btl_pkg::OP_CHAR;
        waddr = btl_pkg::GLYPH_ADDR_BITS'(item.char_code - btl_pkg::CODE_FIRST);
        raddr = btl_pkg::GLYPH_ADDR_BITS'(rd_code - btl_pkg::CODE_FIRST);

        wdata.sx  = item.src_x;
        wdata.sy  = item.src_y;
        wdata.w   = item.src_w;
        wdata.h   = item.src_h;
        wdata.xo  = item.x_offset;
        wdata.yo  = item.y_offset;
        wdata.adv = item.advance;

        issue.is_newline = item.char_code == btl_pkg::CODE_NEWLINE;
        issue.is_space   = item.char_code == btl_pkg::CODE_SPACE;
        issue.last       = item.last;
        issue.origin_x   = item.origin_x;
        issue.origin_y   = item.origin_y;
    end

    btl_ram #(
        .WIDTH (btl_pkg::GLYPH_BITS),
        .DEPTH (btl_pkg::GLYPH_COUNT)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    btl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (re),
        .issue       (issue),
        .issue_ready (issue_ready),
        .glyph       (rdata),
        .line_skip   (line_skip_reg),
        .line_height (line_height_reg),
        .result      (result)
    );

endmodule

// File: bench/bitmap_text_layout_check.sv
`timescale 1ns / 1ps

module bitmap_text_layout_check (
    input  logic  clk,
    input  logic  rst_n,
    btl_item_if   item,
    btl_result_if result,
    btl_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding
);
    import btl_pkg::*;

    typedef struct packed {
        logic        draw_valid;
        logic [11:0] blit_src_x;
        logic [11:0] blit_src_y;
        logic [7:0]  blit_w;
        logic [7:0]  blit_h;
        coord_t      dest_x;
        coord_t      dest_y;
        coord_t      end_x;
        coord_t      end_y;
        extent_t     extent_w;
        extent_t     extent_h;
        logic        last_out;
    } layout_result_t;

    localparam longint COORD_HI  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO  = -COORD_HI - 1;
    localparam longint EXTENT_HI = longint'(EXT_MAX);

    glyph_t         glyph_ram [GLYPH_COUNT];
    longint         cursor_x;
    longint         cursor_y;
    longint         start_x;
    longint         start_y;
    longint         span_w;
    longint         span_h;
    logic           mid_string;
    logic [7:0]     line_skip;
    logic [7:0]     line_height;
    layout_result_t expected_q [$];
    layout_result_t want;
    glyph_t         fresh_glyph;

    function automatic longint clamp_coord(input longint v);
        longint r;
        r = v;
        if (v > COORD_HI)
        begin
            r = COORD_HI;
        end
        else if (v < COORD_LO)
        begin
            r = COORD_LO;
        end
        return r;
    endfunction

    function automatic longint clamp_extent(input longint v);
        longint r;
        r = v;
        if (v > EXTENT_HI)
        begin
            r = EXTENT_HI;
        end
        else if (v < 0)
        begin
            r = 0;
        end
        return r;
    endfunction

    function automatic longint larger(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // advances the cursor and extents for one character beat
    function automatic layout_result_t lay_out_char(input logic [7:0] code_in,
                                                    input logic last,
                                                    input coord_t org_x,
                                                    input coord_t org_y);
        layout_result_t r;
        glyph_t         g;
        logic [7:0]     code;
        longint         adv;
        longint         xo;
        longint         yo;
        longint         gw;
        longint         skip;
        longint         height;
        r      = '0;
        code   = code_in;
        skip   = longint'(line_skip);
        height = longint'(line_height);
        if (!mid_string)
        begin
            start_x  = longint'(org_x);
            start_y  = longint'(org_y);
            cursor_x = 0;
            cursor_y = 0;
            span_w   = 0;
            span_h   = height;
        end
        mid_string = !last;
        if (code == CODE_NEWLINE)
        begin
            cursor_x = 0;
            cursor_y = clamp_coord(cursor_y + skip);
            span_h   = clamp_extent(larger(span_h, cursor_y + height));
        end
        else
        begin
            if (code < CODE_FIRST || code > CODE_LAST)
            begin
                code = CODE_QMARK;
            end
            g   = glyph_ram[int'(code) - int'(CODE_FIRST)];
            adv = longint'(g.adv);
            xo  = longint'($signed(g.xo));
            yo  = longint'($signed(g.yo));
            gw  = longint'(g.w);
            if (code == CODE_SPACE)
            begin
                span_w = clamp_extent(larger(span_w, cursor_x + adv));
            end
            else
            begin
                r.draw_valid = 1'b1;
                r.blit_src_x = g.sx;
                r.blit_src_y = g.sy;
                r.blit_w     = g.w;
                r.blit_h     = g.h;
                r.dest_x     = coord_t'(clamp_coord(start_x + cursor_x + xo));
                r.dest_y     = coord_t'(clamp_coord(start_y + cursor_y + yo));
                span_w       = clamp_extent(larger(span_w, cursor_x + xo + gw));
            end
            span_h   = clamp_extent(larger(span_h, cursor_y + height));
            cursor_x = clamp_coord(cursor_x + adv);
        end
        r.end_x    = coord_t'(clamp_coord(start_x + cursor_x));
        r.end_y    = coord_t'(clamp_coord(start_y + cursor_y));
        r.extent_w = extent_t'(span_w);
        r.extent_h = extent_t'(span_h);
        r.last_out = last;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x    = 0;
            cursor_y    = 0;
            start_x     = 0;
            start_y     = 0;
            span_w      = 0;
            span_h      = 0;
            mid_string  = 1'b0;
            line_skip   = '0;
            line_height = '0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result beat always belongs to an earlier character, so it goes first
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat expected none got dest %0h,%0h end %0h,%0h",
                             $time, result.dest_x, result.dest_y, result.end_x, result.end_y);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("draw_valid", 16'(want.draw_valid), 16'(result.draw_valid));
                    check_field("blit_src_x", 16'(want.blit_src_x), 16'(result.blit_src_x));
                    check_field("blit_src_y", 16'(want.blit_src_y), 16'(result.blit_src_y));
                    check_field("blit_w", 16'(want.blit_w), 16'(result.blit_w));
                    check_field("blit_h", 16'(want.blit_h), 16'(result.blit_h));
                    check_field("dest_x", 16'(want.dest_x), 16'(result.dest_x));
                    check_field("dest_y", 16'(want.dest_y), 16'(result.dest_y));
                    check_field("end_x", 16'(want.end_x), 16'(result.end_x));
                    check_field("end_y", 16'(want.end_y), 16'(result.end_y));
                    check_field("extent_w", 16'(want.extent_w), 16'(result.extent_w));
                    check_field("extent_h", 16'(want.extent_h), 16'(result.extent_h));
                    check_field("last_out", 16'(want.last_out), 16'(result.last_out));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LINE_SKIP:   line_skip   = cfg.data;
                    REG_LINE_HEIGHT: line_height = cfg.data;
                    default:         ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (item.op == OP_WRITE)
                begin
                    if (item.char_code >= CODE_FIRST && item.char_code <= CODE_LAST)
                    begin
                        fresh_glyph.sx  = item.src_x;
                        fresh_glyph.sy  = item.src_y;
                        fresh_glyph.w   = item.src_w;
                        fresh_glyph.h   = item.src_h;
                        fresh_glyph.xo  = item.x_offset;
                        fresh_glyph.yo  = item.y_offset;
                        fresh_glyph.adv = item.advance;
                        glyph_ram[int'(item.char_code) - int'(CODE_FIRST)] = fresh_glyph;
                    end
                end
                else
                begin
                    expected_q.push_back(lay_out_char(item.char_code, item.last,
                                                      item.origin_x, item.origin_y));
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// File: bench/bitmap_text_layout_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_text_layout_unit_tb;
    import btl_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_HOLD   = 400;
    localparam int SAT_PHASE       = 1;
    localparam int SAT_RUN         = 140;

    localparam logic [7:0] CODE_UPPER_A = 8'd65;
    localparam logic [7:0] CODE_WIDE    = 8'd87;

    typedef struct packed {
        logic              op;
        logic [7:0]        char_code;
        logic              last;
        logic [11:0]       src_x;
        logic [11:0]       src_y;
        logic [7:0]        src_w;
        logic [7:0]        src_h;
        logic signed [7:0] x_offset;
        logic signed [7:0] y_offset;
        logic [7:0]        advance;
        coord_t            origin_x;
        coord_t            origin_y;
    } item_beat_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   hold_left;
    int   items_sent;
    int   quiet_cycles;
    bit   glyph_loaded [GLYPH_COUNT];

    btl_item_if   item ();
    btl_result_if result ();
    btl_cfg_if    cfg ();

    bitmap_text_layout_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    bitmap_text_layout_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int glyph_slot(input logic [7:0] c);
        int s;
        if (c < CODE_FIRST || c > CODE_LAST)
        begin
            s = int'(CODE_QMARK) - int'(CODE_FIRST);
        end
        else
        begin
            s = int'(c) - int'(CODE_FIRST);
        end
        return s;
    endfunction

    function automatic coord_t rand_coord();
        int unsigned r;
        coord_t      c;
        r = $urandom_range(99);
        if (r < 8)
        begin
            c = COORD_MAX;
        end
        else if (r < 16)
        begin
            c = COORD_MIN;
        end
        else if (r < 20)
        begin
            c = '0;
        end
        else
        begin
            c = coord_t'($urandom);
        end
        return c;
    endfunction

    // only codes whose glyph slot has been loaded are laid out
    function automatic logic [7:0] pick_code();
        logic [7:0]  c;
        int unsigned r;
        logic        found;
        found = 1'b0;
        c     = CODE_NEWLINE;
        for (int t = 0; t < 8 && !found; t++)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                c     = CODE_NEWLINE;
                found = 1'b1;
            end
            else
            begin
                if (r < 22)
                begin
                    c = CODE_SPACE;
                end
                else if (r < 30)
                begin
                    c = 8'($urandom_range(31, 0));
                end
                else if (r < 38)
                begin
                    c = 8'($urandom_range(255, 127));
                end
                else
                begin
                    c = 8'($urandom_range(126, 33));
                end
                found = (c == CODE_NEWLINE) || glyph_loaded[glyph_slot(c)];
            end
        end
        if (!found)
        begin
            c = CODE_NEWLINE;
        end
        return c;
    endfunction

    task automatic offer_beat(input item_beat_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid     <= 1'b1;
        item.op        <= b.op;
        item.char_code <= b.char_code;
        item.last      <= b.last;
        item.src_x     <= b.src_x;
        item.src_y     <= b.src_y;
        item.src_w     <= b.src_w;
        item.src_h     <= b.src_h;
        item.x_offset  <= b.x_offset;
        item.y_offset  <= b.y_offset;
        item.advance   <= b.advance;
        item.origin_x  <= b.origin_x;
        item.origin_y  <= b.origin_y;
        do
            @(posedge clk);
        while (!item.ready);
        if (b.op == OP_CHAR || (b.char_code >= CODE_FIRST && b.char_code <= CODE_LAST))
        begin
            items_sent++;
        end
    endtask

    task automatic load_glyph(input logic [7:0] code, input logic [11:0] sx,
                              input logic [11:0] sy, input logic [7:0] w,
                              input logic [7:0] h, input logic [7:0] xo,
                              input logic [7:0] yo, input logic [7:0] adv);
        item_beat_t b;
        b.op        = OP_WRITE;
        b.char_code = code;
        b.last      = 1'($urandom);
        b.src_x     = sx;
        b.src_y     = sy;
        b.src_w     = w;
        b.src_h     = h;
        b.x_offset  = xo;
        b.y_offset  = yo;
        b.advance   = adv;
        b.origin_x  = coord_t'($urandom);
        b.origin_y  = coord_t'($urandom);
        if (code >= CODE_FIRST && code <= CODE_LAST)
        begin
            glyph_loaded[int'(code) - int'(CODE_FIRST)] = 1'b1;
        end
        offer_beat(b);
    endtask

    task automatic load_random_glyph();
        logic [7:0] code;
        if ($urandom_range(99) < 90)
        begin
            code = 8'($urandom_range(126, 32));
        end
        else if ($urandom_range(1) == 0)
        begin
            code = 8'($urandom_range(31, 0));
        end
        else
        begin
            code = 8'($urandom_range(255, 127));
        end
        load_glyph(code, 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_char(input logic [7:0] code, input logic last,
                             input coord_t org_x, input coord_t org_y);
        item_beat_t b;
        b.op        = OP_CHAR;
        b.char_code = code;
        b.last      = last;
        b.src_x     = 12'($urandom);
        b.src_y     = 12'($urandom);
        b.src_w     = 8'($urandom);
        b.src_h     = 8'($urandom);
        b.x_offset  = 8'($urandom);
        b.y_offset  = 8'($urandom);
        b.advance   = 8'($urandom);
        b.origin_x  = org_x;
        b.origin_y  = org_y;
        offer_beat(b);
    endtask

    // origins after the first beat of a string are ignored by the block
    task automatic lay_out_string(input int len, input logic close);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 4)
            begin
                load_random_glyph();
            end
            send_char(pick_code(), (k == len - 1) && close, rand_coord(), rand_coord());
        end
    endtask

    // pushes cursor and extents into saturation on both axes
    task automatic run_to_saturation();
        load_glyph(CODE_WIDE, 12'($urandom), 12'($urandom), 8'd255, 8'($urandom),
                   8'h7F, 8'($urandom), 8'd255);
        for (int k = 0; k < SAT_RUN; k++)
        begin
            send_char(CODE_WIDE, 1'b0, rand_coord(), rand_coord());
        end
        for (int k = 0; k < SAT_RUN; k++)
        begin
            send_char(CODE_NEWLINE, k == SAT_RUN - 1, rand_coord(), rand_coord());
        end
    endtask

    // valid stays up between back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [7:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    // glyph beats leave nothing to wait for, so keep draining past the last result until none is outstanding
    task automatic settle();
        item.valid <= 1'b0;
        do
        begin
            while (outstanding != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item.valid && item.ready) || (result.valid && result.ready)
                || (cfg.valid && cfg.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] skip;
        logic [7:0] height;
        int         phase_start;
        rst_n          = 1'b0;
        item.valid     = 1'b0;
        item.op        = OP_WRITE;
        item.char_code = '0;
        item.last      = 1'b0;
        item.src_x     = '0;
        item.src_y     = '0;
        item.src_w     = '0;
        item.src_h     = '0;
        item.x_offset  = '0;
        item.y_offset  = '0;
        item.advance   = '0;
        item.origin_x  = '0;
        item.origin_y  = '0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_LINE_SKIP;
        cfg.data       = '0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_left      = 0;
        items_sent     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, unprintable codes, ignored writes, string restarts
        load_glyph(CODE_QMARK, 12'd12, 12'd34, 8'd6, 8'd9, 8'h01, 8'hFE, 8'd7);
        load_glyph(CODE_SPACE, 12'd0, 12'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'd5);
        load_glyph(CODE_UPPER_A, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'hFF);
        load_glyph(CODE_LAST, 12'h000, 12'h000, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h00);
        load_glyph(8'd0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF);
        load_glyph(8'd31, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF);
        load_glyph(8'd127, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF);
        load_glyph(8'd255, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF);
        send_char(CODE_UPPER_A, 1'b0, COORD_MAX, COORD_MAX);
        send_char(CODE_LAST, 1'b0, COORD_MIN, COORD_MIN);
        send_char(CODE_NEWLINE, 1'b0, '0, '0);
        send_char(8'd0, 1'b0, '0, '0);
        send_char(8'd127, 1'b0, '0, '0);
        send_char(8'd255, 1'b0, '0, '0);
        send_char(CODE_SPACE, 1'b0, '0, '0);
        send_char(CODE_UPPER_A, 1'b1, '0, '0);
        send_char(CODE_UPPER_A, 1'b1, COORD_MIN, COORD_MIN);
        send_char(CODE_NEWLINE, 1'b1, '0, '0);
        send_char(CODE_SPACE, 1'b1, -16'sd5, 16'sd7);
        send_char(CODE_QMARK, 1'b1, 16'sd100, -16'sd100);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:       begin skip = 8'd0;   height = 8'd0;   end
                1:       begin skip = 8'd255; height = 8'd255; end
                2:       begin skip = 8'd0;   height = 8'd255; end
                3:       begin skip = 8'd255; height = 8'd0;   end
                default: begin skip = 8'($urandom); height = 8'($urandom); end
            endcase
            write_reg(REG_LINE_SKIP, skip);
            write_reg(REG_LINE_HEIGHT, height);
            cfg.valid <= 1'b0;
            case (p % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 60; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 60; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            if (p == PRESSURE_PHASE)
            begin
                hold_left = PRESSURE_HOLD;
            end
            if (p == SAT_PHASE)
            begin
                run_to_saturation();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 12)
                begin
                    load_random_glyph();
                end
                else if ($urandom_range(99) < 8)
                begin
                    lay_out_string(int'($urandom_range(60, 30)), $urandom_range(99) >= 8);
                end
                else
                begin
                    lay_out_string(int'($urandom_range(12, 1)), $urandom_range(99) >= 8);
                end
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
